### src/assert_macros.svh
// assertion macros used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that holds at every clock edge out of reset
`define CHECK_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// signal that must stay high out of reset
`define CHECK_HIGH(label, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (sig)) else $error(msg);
`else
`define CHECK_PROP(label, prop, msg)
`define CHECK_HIGH(label, sig, msg)
`endif
`endif

### src/ibma_pkg.sv
package ibma_pkg;

	localparam int INODE_COUNT     = 64;
	localparam int BLOCK_COUNT     = 256;
	localparam int BLOCK_BYTES     = 512;
	localparam int DIRECT_POINTERS = 7;

	localparam int CMD_W    = 2;
	localparam int INODE_W  = 6;
	localparam int BLK_W    = 8;
	localparam int BOFF_W   = 9;
	localparam int SEG_W    = 10;
	localparam int TOTAL_W  = 12;
	localparam int STATUS_W = 2;

	localparam int WORD_W      = 32;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int INODE_WORDS = (INODE_COUNT + WORD_W - 1) / WORD_W;
	localparam int BLOCK_WORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
	localparam int IWW         = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
	localparam int BWW         = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int K_W         = (DIRECT_POINTERS > 1) ? $clog2(DIRECT_POINTERS) : 1;
	localparam int PTR_DEPTH   = INODE_COUNT * DIRECT_POINTERS;
	localparam int PTR_AW      = $clog2(PTR_DEPTH);
	localparam int DONE_W      = $clog2(DIRECT_POINTERS * BLOCK_BYTES + 1);

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_INODE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_INODE  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [INODE_W-1:0] inode_index;
		logic [31:0]        byte_offset;
		logic [31:0]        byte_length;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INODE_W-1:0]  new_inode;
		logic [BLK_W-1:0]    block_number;
		logic [BOFF_W-1:0]   block_offset;
		logic [SEG_W-1:0]    segment_bytes;
		logic                fresh_block;
		logic [TOTAL_W-1:0]  total_bytes;
		logic                last;
	} res_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] index;
	} find_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_ISRCH, ST_CLR, ST_ADONE, ST_FREE_RD, ST_FREE_WR,
		ST_SZ_RD, ST_SZ, ST_SEG, ST_PTR, ST_BSRCH, ST_END
	} state_t;

endpackage

### src/ibma_ram.sv
module ibma_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### src/ibma_zero_find.sv
module ibma_zero_find
	import ibma_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	output find_t             res
);

	// lowest clear bit of one bitmap word
	always_comb begin
		res = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				res.found = 1'b1;
				res.index = BIT_W'(i);
			end
		end
	end

endmodule

### src/inode_block_map_allocator.sv
// Inode and block map allocator. A command is taken when start is high and busy
// is low; busy then stays high until the cycle that carries the command's last
// result. Results appear on result for one cycle each, marked by result_valid, and
// cannot be held off by the receiver; result.last marks the final one. File sizes
// and direct pointers live in two single-port memories with registered reads, the
// inode and block bitmaps in flip-flops scanned one 32-bit word per cycle. No
// clearing pass runs after reset: a valid bit per inode row marks pointers never
// written, and the first command on such a row clears it.
// Allocate searches the inode bitmap word by word, then clears the new row;
// free reads and then writes each of the 7 pointers in turn; write and read map
// walk the range segment by segment, a write searching the block bitmap for
// each block it allocates; a hole ends a read's walk and a full block bitmap a
// write's, and every segment lookup and update goes through the single pointer
// memory port.
module inode_block_map_allocator
	import ibma_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t cmd,
	output logic busy,
	output logic result_valid,
	output res_t result
);

`include "assert_macros.svh"

	state_t state_q, state_d, after_q, after_d;

	req_t                   req_q;
	logic [INODE_COUNT-1:0] inode_used_q;
	logic [BLOCK_COUNT-1:0] block_used_q;
	logic [INODE_COUNT-1:0] row_valid_q;
	logic [K_W-1:0]         k_q;
	logic [IWW-1:0]         iw_q;
	logic [BWW-1:0]         bw_q;
	logic [31:0]            size_q;
	logic [31:0]            len_q;
	logic [DONE_W-1:0]      done_q;
	logic [BOFF_W-1:0]      boff_q;
	logic [SEG_W-1:0]       seg_q;
	res_t                   pend_q;
	logic                   pend_v_q;
	res_t                   result_q;
	logic                   result_valid_q;

	// memory ports
	logic              ptr_en, ptr_we;
	logic [PTR_AW-1:0] ptr_addr;
	logic [BLK_W-1:0]  ptr_wdata, ptr_rdata;
	logic              sz_en, sz_we;
	logic [31:0]       sz_wdata, sz_rdata;

	ibma_ram #(.DEPTH(PTR_DEPTH), .WIDTH(BLK_W)) u_ptr_ram (
		.clk(clk), .en(ptr_en), .we(ptr_we), .addr(ptr_addr),
		.wdata(ptr_wdata), .rdata(ptr_rdata)
	);

	ibma_ram #(.DEPTH(INODE_COUNT), .WIDTH(32)) u_size_ram (
		.clk(clk), .en(sz_en), .we(sz_we), .addr(req_q.inode_index),
		.wdata(sz_wdata), .rdata(sz_rdata)
	);

	// bitmaps padded to whole words, padding reads as used
	logic [INODE_WORDS*WORD_W-1:0] ipad;
	logic [BLOCK_WORDS*WORD_W-1:0] bpad;
	always_comb begin
		ipad = '1;
		bpad = '1;
		ipad[INODE_COUNT-1:0] = inode_used_q;
		bpad[BLOCK_COUNT-1:0] = block_used_q;
	end

	find_t ifind, bfind;
	ibma_zero_find u_ifind (.word(ipad[iw_q*WORD_W +: WORD_W]), .res(ifind));
	ibma_zero_find u_bfind (.word(bpad[bw_q*WORD_W +: WORD_W]), .res(bfind));

	logic [INODE_W-1:0] ifound_idx;
	logic [BLK_W-1:0]   bfound_idx;
	assign ifound_idx = INODE_W'({iw_q, ifind.index});
	assign bfound_idx = BLK_W'({bw_q, bfind.index});

	// segment arithmetic
	logic [32:0]         pos;
	logic [32-BOFF_W:0]  idx;
	logic                idx_ok;
	logic [31:0]         remain;
	logic [SEG_W-1:0]    seg_cap;
	logic [SEG_W-1:0]    seg;
	logic                range_done;
	logic [PTR_AW-1:0]   base;
	logic [32:0]         end_pos;
	logic [31:0]         end_sat;
	logic [32:0]         rd_end;
	logic                inode_ok;

	assign pos        = {1'b0, req_q.byte_offset} + 33'(done_q);
	assign idx        = pos[32:BOFF_W];
	assign idx_ok     = idx < (33 - BOFF_W)'(DIRECT_POINTERS);
	assign remain     = len_q - 32'(done_q);
	assign seg_cap    = SEG_W'(BLOCK_BYTES) - SEG_W'(pos[BOFF_W-1:0]);
	assign seg        = (remain < 32'(seg_cap)) ? SEG_W'(remain) : seg_cap;
	assign range_done = 32'(done_q) >= len_q;
	assign base       = PTR_AW'(req_q.inode_index) * PTR_AW'(DIRECT_POINTERS);
	assign end_pos    = {1'b0, req_q.byte_offset} + 33'(done_q);
	assign end_sat    = end_pos[32] ? '1 : end_pos[31:0];
	assign rd_end     = {1'b0, req_q.byte_offset} + {1'b0, req_q.byte_length};
	assign inode_ok   = (req_q.inode_index != '0) && inode_used_q[req_q.inode_index];

	// next state, memory control and result selection
	logic emit;
	res_t emit_res;
	logic new_seg;
	logic seg_fresh;
	logic [BLK_W-1:0] seg_blk;

	always_comb begin
		state_d   = state_q;
		after_d   = after_q;
		ptr_en    = 1'b0;
		ptr_we    = 1'b0;
		ptr_addr  = base + PTR_AW'(k_q);
		ptr_wdata = '0;
		sz_en     = 1'b0;
		sz_we     = 1'b0;
		sz_wdata  = '0;
		emit      = 1'b0;
		emit_res  = '0;
		emit_res.last = 1'b1;
		new_seg   = 1'b0;
		seg_fresh = 1'b0;
		seg_blk   = ptr_rdata;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (req_q.command == CMD_ALLOC) begin
					state_d = ST_ISRCH;
				end else if (!inode_ok) begin
					emit = 1'b1;
					emit_res.status = STAT_BAD_INODE;
					state_d = ST_IDLE;
				end else begin
					after_d = (req_q.command == CMD_FREE) ? ST_FREE_RD : ST_SZ_RD;
					state_d = row_valid_q[req_q.inode_index] ? after_d : ST_CLR;
				end
			end
			ST_ISRCH: begin
				if (ifind.found) begin
					after_d = ST_ADONE;
					state_d = ST_CLR;
				end else if (iw_q == IWW'(INODE_WORDS - 1)) begin
					emit = 1'b1;
					emit_res.status = STAT_NO_INODE;
					state_d = ST_IDLE;
				end
			end
			ST_CLR: begin
				ptr_en = 1'b1;
				ptr_we = 1'b1;
				if (k_q == '0) begin
					sz_en = 1'b1;
					sz_we = 1'b1;
				end
				if (k_q == K_W'(DIRECT_POINTERS - 1)) state_d = after_q;
			end
			ST_ADONE: begin
				emit = 1'b1;
				emit_res.new_inode = req_q.inode_index;
				state_d = ST_IDLE;
			end
			ST_FREE_RD: begin
				ptr_en = 1'b1;
				state_d = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				ptr_en = 1'b1;
				ptr_we = 1'b1;
				if (k_q == K_W'(DIRECT_POINTERS - 1)) begin
					emit = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_FREE_RD;
				end
			end
			ST_SZ_RD: begin
				sz_en = 1'b1;
				state_d = ST_SZ;
			end
			ST_SZ: begin
				state_d = ST_SEG;
			end
			ST_SEG: begin
				if (range_done || !idx_ok) begin
					state_d = ST_END;
				end else begin
					ptr_en   = 1'b1;
					ptr_addr = base + PTR_AW'(idx[K_W-1:0]);
					state_d  = ST_PTR;
				end
			end
			ST_PTR: begin
				if (ptr_rdata != '0) begin
					new_seg = 1'b1;
					state_d = ST_SEG;
				end else if (req_q.command == CMD_WRITE) begin
					state_d = ST_BSRCH;
				end else begin
					state_d = ST_END;
				end
			end
			ST_BSRCH: begin
				if (bfind.found) begin
					ptr_en    = 1'b1;
					ptr_we    = 1'b1;
					ptr_wdata = bfound_idx;
					new_seg   = 1'b1;
					seg_fresh = 1'b1;
					seg_blk   = bfound_idx;
					state_d   = ST_SEG;
				end else if (bw_q == BWW'(BLOCK_WORDS - 1)) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				emit = 1'b1;
				if (pend_v_q) begin
					emit_res = pend_q;
					emit_res.last = 1'b1;
				end
				if (req_q.command == CMD_WRITE && end_sat > size_q) begin
					sz_en    = 1'b1;
					sz_we    = 1'b1;
					sz_wdata = end_sat;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// a new segment pushes out the one held back
		if (new_seg && pend_v_q) begin
			emit = 1'b1;
			emit_res = pend_q;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
		end
	end

	// bitmaps, row valid bits and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_used_q    <= INODE_COUNT'(3);
			block_used_q    <= BLOCK_COUNT'(1);
			row_valid_q     <= '0;
			k_q             <= '0;
			iw_q            <= '0;
			bw_q            <= '0;
			pend_v_q        <= 1'b0;
			result_valid_q  <= 1'b0;
		end else begin
			result_valid_q <= emit;
			case (state_q)
				ST_DECODE: begin
					k_q  <= '0;
					iw_q <= '0;
				end
				ST_ISRCH: begin
					if (ifind.found) begin
						inode_used_q[ifound_idx] <= 1'b1;
					end else if (iw_q != IWW'(INODE_WORDS - 1)) begin
						iw_q <= iw_q + 1'b1;
					end
				end
				ST_CLR: begin
					if (k_q == K_W'(DIRECT_POINTERS - 1)) begin
						row_valid_q[req_q.inode_index] <= 1'b1;
						k_q <= '0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_FREE_WR: begin
					if (ptr_rdata != '0 && 32'(ptr_rdata) < 32'(BLOCK_COUNT)) begin
						block_used_q[ptr_rdata] <= 1'b0;
					end
					if (k_q == K_W'(DIRECT_POINTERS - 1)) begin
						inode_used_q[req_q.inode_index] <= 1'b0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SZ: begin
					pend_v_q <= 1'b0;
				end
				ST_SEG: begin
					k_q  <= idx[K_W-1:0];
					bw_q <= '0;
				end
				ST_BSRCH: begin
					if (bfind.found) begin
						block_used_q[bfound_idx] <= 1'b1;
					end else if (bw_q != BWW'(BLOCK_WORDS - 1)) begin
						bw_q <= bw_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (new_seg) pend_v_q <= 1'b1;
		end
	end

	// request and segment payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= cmd;
			len_q <= cmd.byte_length;
		end
		if (state_q == ST_ISRCH && ifind.found) req_q.inode_index <= ifound_idx;
		if (state_q == ST_SZ) begin
			size_q <= sz_rdata;
			done_q <= '0;
			if (req_q.command == CMD_READ) begin
				if (req_q.byte_offset >= sz_rdata) begin
					len_q <= '0;
				end else if (rd_end > {1'b0, sz_rdata}) begin
					len_q <= sz_rdata - req_q.byte_offset;
				end
			end
		end
		if (state_q == ST_SEG) begin
			boff_q <= pos[BOFF_W-1:0];
			seg_q  <= seg;
		end
		if (new_seg) begin
			pend_q.status        <= STAT_OK;
			pend_q.new_inode     <= '0;
			pend_q.block_number  <= seg_blk;
			pend_q.block_offset  <= boff_q;
			pend_q.segment_bytes <= seg_q;
			pend_q.fresh_block   <= seg_fresh;
			pend_q.total_bytes   <= TOTAL_W'(done_q + DONE_W'(seg_q));
			pend_q.last          <= 1'b0;
			done_q <= done_q + DONE_W'(seg_q);
		end
		if (emit) result_q <= emit_res;
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	`CHECK_PROP(a_start_busy, start && !busy |=> busy, "accepted command did not raise busy")
	`CHECK_PROP(a_last_gap, result_valid && result.last |=> !result_valid, "result after last")
	`CHECK_HIGH(a_block0_rsvd, block_used_q[0], "block 0 released")
	`CHECK_HIGH(a_inode0_rsvd, inode_used_q[0], "inode 0 released")

endmodule
